FILE: rtl/adpcm_block_decoder_assert.svh
// assertion macros for the adpcm block decoder
// used by the queue and the back end, needs clk_i and rst_ni in scope
`ifndef ADPCM_BLOCK_DECODER_ASSERT_SVH
`define ADPCM_BLOCK_DECODER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define ADBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define ADBD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define ADBD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ADBD_ASSERT(lbl, prop, msg)
`define ADBD_ASSERT_IMPL(lbl, ante, cons, msg)
`define ADBD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/adpcm_bd_pkg.sv
// types, constants and coefficient tables of the adpcm block decoder
// no dependencies
package adpcm_bd_pkg;

  localparam int unsigned ShiftW  = 4;
  localparam int unsigned FilterW = 3;
  localparam int unsigned PosW    = 4;

  localparam logic [ShiftW-1:0]  MaxShift  = 4'd12;
  localparam logic [FilterW-1:0] MaxFilter = 3'd4;
  localparam logic [PosW-1:0]    PosHeader = 4'd0;
  localparam logic [PosW-1:0]    PosFlags  = 4'd1;

  localparam logic KindSample = 1'b0;
  localparam logic KindFlags  = 1'b1;

  localparam logic signed [15:0] SampleMax = 16'sh7FFF;
  localparam logic signed [15:0] SampleMin = -16'sh8000;

  // work queued from front to back
  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_FLAGS,
    OP_DATA
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [7:0]         data;
    logic [ShiftW-1:0]  shift;
    logic [FilterW-1:0] filter;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  // weight of the previous sample
  function automatic logic signed [7:0] coef_pos(input logic [FilterW-1:0] sel);
    logic signed [7:0] c;
    case (sel)
      3'd1:    c = 8'sd60;
      3'd2:    c = 8'sd115;
      3'd3:    c = 8'sd98;
      3'd4:    c = 8'sd122;
      default: c = 8'sd0;
    endcase
    return c;
  endfunction

  // weight of the sample before the previous one
  function automatic logic signed [7:0] coef_neg(input logic [FilterW-1:0] sel);
    logic signed [7:0] c;
    case (sel)
      3'd2:    c = -8'sd52;
      3'd3:    c = -8'sd55;
      3'd4:    c = -8'sd60;
      default: c = 8'sd0;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/adpcm_bd_if.sv
// valid/ready channel interfaces of the adpcm block decoder
// byte input channel and result output channel, no dependencies
interface adpcm_bd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_voice;

  modport source (output valid, output data_byte, output start_voice, input ready);
  modport sink   (input valid, input data_byte, input start_voice, output ready);
endinterface

interface adpcm_bd_out_if;
  logic               valid;
  logic               ready;
  logic               item_kind;
  logic signed [15:0] pcm_sample;
  logic [7:0]         block_flags;
  logic               last_of_byte;

  modport source (output valid, output item_kind, output pcm_sample, output block_flags,
                  output last_of_byte, input ready);
  modport sink   (input valid, input item_kind, input pcm_sample, input block_flags,
                  input last_of_byte, output ready);
endinterface

FILE: rtl/adpcm_bd_fifo.sv
// short queue of work entries between front and back end
// depends on adpcm_bd_pkg and adpcm_block_decoder_assert.svh
`include "adpcm_block_decoder_assert.svh"

module adpcm_bd_fifo import adpcm_bd_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  entry_t  push_entry_i,
  input  logic    pop_i,
  output entry_t  head_o,
  output q_stat_t stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;

  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == CntW'(Depth));
  assign head_o       = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  `ADBD_ASSERT(a_fifo_count_bound, count_q <= CntW'(Depth), "queue fill count above depth")
  `ADBD_ASSERT_IMPL(a_fifo_no_underflow, pop_i, !stat_o.empty, "pop from empty queue")

endmodule

FILE: rtl/adpcm_bd_front.sv
// front end: takes bytes, tracks block position, decodes the header
// depends on adpcm_bd_pkg and adpcm_bd_in_if
module adpcm_bd_front import adpcm_bd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  adpcm_bd_in_if.sink         byte_i,
  input  q_stat_t             q_stat_i,
  output logic                push_o,
  output entry_t              push_entry_o
);

  logic [PosW-1:0]    pos_q, pos_d;
  logic [ShiftW-1:0]  shift_q, shift_d;
  logic [FilterW-1:0] filter_q, filter_d;
  logic [PosW-1:0]    pos_cur;
  logic               accept;
  logic [3:0]         low_nib;
  logic [2:0]         filt_raw;

  assign byte_i.ready = !q_stat_i.full;
  assign accept       = byte_i.valid && byte_i.ready;

  // start of voice forces a header
  assign pos_cur  = byte_i.start_voice ? PosHeader : pos_q;
  assign low_nib  = byte_i.data_byte[3:0];
  assign filt_raw = byte_i.data_byte[6:4];

  // header decode and position step
  always_comb begin
    pos_d    = pos_q;
    shift_d  = shift_q;
    filter_d = filter_q;
    if (accept) begin
      pos_d = pos_cur + 1'b1;
      if (pos_cur == PosHeader) begin
        shift_d  = (low_nib > MaxShift) ? '0 : MaxShift - low_nib;
        filter_d = (filt_raw > MaxFilter) ? MaxFilter : filt_raw;
      end
    end
  end

  // queue entry: clear on voice start, flags byte, or data byte
  always_comb begin
    push_o              = accept && (pos_cur != PosHeader || byte_i.start_voice);
    push_entry_o.data   = byte_i.data_byte;
    push_entry_o.shift  = shift_q;
    push_entry_o.filter = filter_q;
    if (pos_cur == PosHeader) begin
      push_entry_o.op = OP_CLEAR;
    end else if (pos_cur == PosFlags) begin
      push_entry_o.op = OP_FLAGS;
    end else begin
      push_entry_o.op = OP_DATA;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= PosHeader;
      shift_q  <= '0;
      filter_q <= '0;
    end else begin
      pos_q    <= pos_d;
      shift_q  <= shift_d;
      filter_q <= filter_d;
    end
  end

endmodule

FILE: rtl/adpcm_bd_back.sv
// back end: decodes one nibble per cycle into the output register while that register is free
// depends on adpcm_bd_pkg, adpcm_bd_out_if and adpcm_block_decoder_assert.svh
`include "adpcm_block_decoder_assert.svh"

module adpcm_bd_back import adpcm_bd_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  entry_t          head_i,
  input  q_stat_t         q_stat_i,
  output logic            pop_o,
  adpcm_bd_out_if.source  result_o
);

  logic signed [15:0] prev_q, prev_d;
  logic signed [15:0] older_q, older_d;
  logic               phase_q, phase_d;

  logic               out_valid_q, out_valid_d;
  logic               kind_q, kind_d;
  logic signed [15:0] pcm_q, pcm_d;
  logic [7:0]         flags_q, flags_d;
  logic               last_q, last_d;

  logic               head_valid;
  logic               out_free;
  logic               step;
  logic [3:0]         nib;
  logic signed [16:0] base;
  logic signed [7:0]  cp;
  logic signed [7:0]  cn;
  logic signed [23:0] prod_a;
  logic signed [23:0] prod_b;
  logic signed [24:0] pred;
  logic signed [24:0] pred_adj;
  logic signed [18:0] quot;
  logic signed [19:0] sum;
  logic signed [15:0] sample;

  assign head_valid = !q_stat_i.empty;
  assign out_free   = !out_valid_q || result_o.ready;

  // nibble scaled by shift
  assign nib  = phase_q ? head_i.data[7:4] : head_i.data[3:0];
  assign base = {{13{nib[3]}}, nib} << head_i.shift;

  // prediction from history plus 32, divided by 64 toward zero
  assign cp       = coef_pos(head_i.filter);
  assign cn       = coef_neg(head_i.filter);
  assign prod_a   = prev_q * cp;
  assign prod_b   = older_q * cn;
  assign pred     = {prod_a[23], prod_a} + {prod_b[23], prod_b} + 25'sd32;
  assign pred_adj = pred + (pred[24] ? 25'sd63 : 25'sd0);
  assign quot     = pred_adj[24:6];
  assign sum      = {quot[18], quot} + {{3{base[16]}}, base};

  // saturate to 16 bits
  always_comb begin
    if (sum > 20'(SampleMax)) begin
      sample = SampleMax;
    end else if (sum < 20'(SampleMin)) begin
      sample = SampleMin;
    end else begin
      sample = sum[15:0];
    end
  end

  // work on the queue head
  always_comb begin
    prev_d      = prev_q;
    older_d     = older_q;
    phase_d     = phase_q;
    out_valid_d = out_valid_q && !result_o.ready;
    kind_d      = kind_q;
    pcm_d       = pcm_q;
    flags_d     = flags_q;
    last_d      = last_q;
    pop_o       = 1'b0;
    step        = 1'b0;
    if (head_valid) begin
      case (head_i.op)
        OP_CLEAR: begin
          prev_d  = '0;
          older_d = '0;
          pop_o   = 1'b1;
        end
        OP_FLAGS: begin
          if (out_free) begin
            out_valid_d = 1'b1;
            kind_d      = KindFlags;
            pcm_d       = '0;
            flags_d     = head_i.data;
            last_d      = 1'b1;
            pop_o       = 1'b1;
          end
        end
        OP_DATA: begin
          if (out_free) begin
            step        = 1'b1;
            out_valid_d = 1'b1;
            kind_d      = KindSample;
            pcm_d       = sample;
            flags_d     = '0;
            last_d      = phase_q;
            older_d     = prev_q;
            prev_d      = sample;
            phase_d     = !phase_q;
            pop_o       = phase_q;
          end
        end
        default: begin
          pop_o = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      older_q     <= '0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      prev_q      <= prev_d;
      older_q     <= older_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    pcm_q   <= pcm_d;
    flags_q <= flags_d;
    last_q  <= last_d;
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.item_kind    = kind_q;
  assign result_o.pcm_sample   = pcm_q;
  assign result_o.block_flags  = flags_q;
  assign result_o.last_of_byte = last_q;

  `ADBD_ASSERT_IMPL(a_back_phase_on_data, phase_q, head_valid && head_i.op == OP_DATA, "high nibble pending without data entry")
  `ADBD_ASSERT_NEXT(a_back_phase_returns, phase_q && step, !phase_q, "phase did not return after high nibble")

endmodule

FILE: rtl/adpcm_block_decoder.sv
// Decoder for 16-byte 4-bit ADPCM blocks fed one byte per word. The front end
// accepts a byte every cycle while its queue has room; a header byte takes no
// back-end time unless it starts a voice (then the back end clears history), the
// flags byte gives one flags result, and each data byte gives two results, one per
// nibble, decoded in turn as the history recurrence runs through a single
// multiply-add-saturate stage. With an empty queue a taken byte passes through the
// queue storage and then the output register before its first result shows. A
// result held in the output register stalls the back end until it is taken, while
// the queue keeps the input open until it fills.
// top level, depends on adpcm_bd_pkg, adpcm_bd_if, front, fifo and back modules
module adpcm_block_decoder import adpcm_bd_pkg::*; #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  adpcm_bd_in_if.sink     byte_i,
  adpcm_bd_out_if.source  result_o
);

  logic    push;
  entry_t  push_entry;
  logic    pop;
  entry_t  head;
  q_stat_t q_stat;

  // byte intake and header decode
  adpcm_bd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_i       (byte_i),
    .q_stat_i     (q_stat),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  // decoupling queue
  adpcm_bd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .head_o       (head),
    .stat_o       (q_stat)
  );

  // sample decode and result register
  adpcm_bd_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .q_stat_i (q_stat),
    .pop_o    (pop),
    .result_o (result_o)
  );

endmodule

FILE: dv/tb_top.sv
// self-checking testbench of the adpcm block decoder: directed and random byte streams
// depends on adpcm_bd_pkg, adpcm_bd_if and adpcm_block_decoder
`timescale 1ns / 1ps

module tb_top import adpcm_bd_pkg::*;;

  localparam int ItemTarget = 1200;
  localparam int MaxIdle    = 10;
  localparam int HoldCycles = 150;
  localparam int TailCycles = 20;
  localparam int QuietLimit = 3000;
  localparam int MaxReports = 10;

  // prediction weights of the two history samples, by filter
  localparam int PrevGain  [0:4] = '{0, 60, 115, 98, 122};
  localparam int OlderGain [0:4] = '{0, 0, -52, -55, -60};

  typedef struct {
    logic [7:0] data;
    logic       voice_start;
    int         gap;
    bit         drain;
    bit         hold;
  } byte_item_t;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] pcm;
    logic [7:0]         flags;
    logic               last;
  } result_word_t;

  logic clk_i;
  logic rst_ni;

  adpcm_bd_in_if  byte_if ();
  adpcm_bd_out_if result_if ();

  adpcm_block_decoder i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_i  (byte_if),
    .result_o(result_if)
  );

  byte_item_t   stream_q[$];
  result_word_t pending_words[$];
  int           err_cnt = 0;
  logic         hold_kick;
  bit           tx_calm = 1'b0;

  // decoder state as the predictor sees it
  logic [PosW-1:0]    blk_pos    = PosHeader;
  logic [ShiftW-1:0]  cur_shift  = '0;
  logic [FilterW-1:0] cur_filter = '0;
  logic signed [15:0] hist1      = '0;
  logic signed [15:0] hist2      = '0;

  // clock and initial input levels
  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    byte_if.valid = 1'b0;
    byte_if.data_byte = '0;
    byte_if.start_voice = 1'b0;
    result_if.ready = 1'b0;
    hold_kick = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic void flag_error(input string msg);
    err_cnt++;
    if (err_cnt <= MaxReports) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
  endfunction

  // one nibble through the prediction filter, history shifts along
  function automatic logic signed [15:0] next_sample(input logic [3:0] nib);
    int t;
    int acc;
    int s;
    t = nib[3] ? int'(nib) - 16 : int'(nib);
    acc = int'(hist1) * PrevGain[cur_filter] + int'(hist2) * OlderGain[cur_filter] + 32;
    s = t * (1 << cur_shift) + acc / 64;
    if (s > int'(SampleMax)) begin
      s = int'(SampleMax);
    end else if (s < int'(SampleMin)) begin
      s = int'(SampleMin);
    end
    hist2 = hist1;
    hist1 = s[15:0];
    return hist1;
  endfunction

  // expected words for one accepted byte
  function automatic void decode_byte(input logic [7:0] b, input logic voice_start);
    result_word_t w;
    int sh;
    if (voice_start) begin
      blk_pos = PosHeader;
      hist1 = '0;
      hist2 = '0;
    end
    if (blk_pos == PosHeader) begin
      sh = int'(MaxShift) - int'(b[3:0]);
      cur_shift = (sh < 0) ? '0 : sh[ShiftW-1:0];
      cur_filter = (b[6:4] > MaxFilter) ? MaxFilter : b[6:4];
    end else if (blk_pos == PosFlags) begin
      w = '{kind: KindFlags, pcm: '0, flags: b, last: 1'b1};
      pending_words.push_back(w);
    end else begin
      w = '{kind: KindSample, pcm: next_sample(b[3:0]), flags: '0, last: 1'b0};
      pending_words.push_back(w);
      w.pcm = next_sample(b[7:4]);
      w.last = 1'b1;
      pending_words.push_back(w);
    end
    blk_pos = blk_pos + 1'b1;
  endfunction

  // queue one byte with its idle gap
  function automatic void push_byte(input logic [7:0] b, input logic voice_start);
    byte_item_t it;
    it.data = b;
    it.voice_start = voice_start;
    it.gap = tx_calm ? 0 : $urandom_range(0, MaxIdle);
    it.drain = 1'b0;
    it.hold = 1'b0;
    stream_q.push_back(it);
  endfunction

  // byte driver
  always @(posedge clk_i or negedge rst_ni) begin : drive_p
    int         gap_cnt;
    bit         cur_hold;
    logic       nv;
    byte_item_t it;
    if (!rst_ni) begin
      gap_cnt = 0;
      cur_hold = 1'b0;
      byte_if.valid <= 1'b0;
      byte_if.data_byte <= '0;
      byte_if.start_voice <= 1'b0;
      hold_kick <= 1'b0;
    end else begin
      hold_kick <= byte_if.valid && byte_if.ready && cur_hold;
      if (byte_if.valid && byte_if.ready) begin
        decode_byte(byte_if.data_byte, byte_if.start_voice);
      end
      nv = byte_if.valid;
      if (!byte_if.valid || byte_if.ready) begin
        nv = 1'b0;
        if (stream_q.size() != 0) begin
          if (gap_cnt < stream_q[0].gap) begin
            gap_cnt++;
          end else if (!(stream_q[0].drain && pending_words.size() != 0)) begin
            it = stream_q.pop_front();
            gap_cnt = 0;
            cur_hold = it.hold;
            nv = 1'b1;
            byte_if.data_byte <= it.data;
            byte_if.start_voice <= it.voice_start;
          end
        end
      end
      byte_if.valid <= nv;
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin : check_p
    int           stall_left;
    int           hold_left;
    bit           rx_calm;
    logic         nr;
    result_word_t got;
    result_word_t want;
    if (!rst_ni) begin
      stall_left = 0;
      hold_left = 0;
      rx_calm = 1'b0;
      result_if.ready <= 1'b0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        got = '{kind: result_if.item_kind, pcm: result_if.pcm_sample,
                flags: result_if.block_flags, last: result_if.last_of_byte};
        if (pending_words.size() == 0) begin
          flag_error($sformatf("word with nothing expected: kind %0b pcm %0d flags %02h last %0b",
                               got.kind, got.pcm, got.flags, got.last));
        end else begin
          want = pending_words.pop_front();
          if (got.kind !== want.kind)
            flag_error($sformatf("item_kind: expected %0b, got %0b", want.kind, got.kind));
          if (got.pcm !== want.pcm)
            flag_error($sformatf("pcm_sample: expected %0d, got %0d", want.pcm, got.pcm));
          if (got.flags !== want.flags)
            flag_error($sformatf("block_flags: expected %02h, got %02h", want.flags, got.flags));
          if (got.last !== want.last)
            flag_error($sformatf("last_of_byte: expected %0b, got %0b", want.last, got.last));
        end
        if ($urandom_range(0, 29) == 0) rx_calm = !rx_calm;
        stall_left = rx_calm ? 0 : $urandom_range(0, MaxIdle);
      end
      if (hold_kick) hold_left = HoldCycles;
      if (hold_left > 0) begin
        hold_left--;
        nr = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        nr = 1'b0;
      end else begin
        nr = 1'b1;
      end
      result_if.ready <= nr;
    end
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk_i) begin : watchdog_p
    int quiet;
    if (!rst_ni || (byte_if.valid && byte_if.ready) ||
        (result_if.valid && result_if.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QuietLimit) begin
        $display("timeout: no word moved for %0d cycles", QuietLimit);
        $display("adpcm_block_decoder verification failed");
        $finish;
      end
    end
  end

  // stimulus and end of run
  initial begin : run_p
    bit   drain_next;
    bit   hold_done;
    bit   drained;
    bit   restart;
    int   nbytes;
    logic [7:0] b;

    drain_next = 1'b0;
    hold_done = 1'b0;
    drained = 1'b0;
    restart = 1'b1;

    // filter 4, full shift, all flags set, saturation both ways
    push_byte(8'h40, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h77, 1'b0);
    push_byte(8'h77, 1'b0);
    push_byte(8'h88, 1'b0);
    push_byte(8'h88, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h08, 1'b0);
    // restart mid-block, filter field 7 and shift nibble 13
    push_byte(8'hFD, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'hF1, 1'b0);
    // filter field 5, shift nibble 15
    push_byte(8'h5F, 1'b1);
    push_byte(8'h04, 1'b0);
    push_byte(8'hA5, 1'b0);
    // filter field 6 with top bit set, shift nibble 12
    push_byte(8'hEC, 1'b1);
    push_byte(8'h01, 1'b0);
    push_byte(8'h96, 1'b0);
    push_byte(8'h69, 1'b0);
    // filter 2, full shift
    push_byte(8'h20, 1'b1);
    push_byte(8'h02, 1'b0);
    push_byte(8'h7F, 1'b0);
    drain_next = 1'b1;

    // random blocks, a few cut short and restarted
    while (stream_q.size() < ItemTarget) begin
      if ($urandom_range(0, 3) == 0) tx_calm = !tx_calm;
      nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 15) : 16;
      for (int k = 0; k < nbytes; k++) begin
        b = 8'($urandom_range(0, 255));
        push_byte(b, (k == 0) && (restart || $urandom_range(0, 7) == 0));
        if (drain_next) begin
          stream_q[$].drain = 1'b1;
          drain_next = 1'b0;
        end
      end
      restart = (nbytes < 16) && ($urandom_range(0, 9) != 0);
      // back up the output, then keep the input busy
      if (!hold_done && stream_q.size() >= 400) begin
        stream_q[$].hold = 1'b1;
        hold_done = 1'b1;
        tx_calm = 1'b1;
      end
      if (!drained && stream_q.size() >= 800) begin
        drain_next = 1'b1;
        drained = 1'b1;
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (stream_q.size() != 0 || byte_if.valid) @(posedge clk_i);
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("adpcm_block_decoder verification clean");
    end else begin
      $display("adpcm_block_decoder verification failed");
    end
    $finish;
  end

endmodule
